// ----- rtl/assert_macros.svh -----
// Assertion helpers included by the queue RTL.
// Each macro samples on the rising edge of clk and is quiet while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge.
`define ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// When the antecedent holds, the consequent must hold at the next edge.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/pqsi_pkg.sv -----
// ----------------------------------------------------------------------------
// pqsi_pkg: shared types for the sorted priority queue.
// Holds the stored entry layout, the result status codes, the beat kinds and field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package pqsi_pkg;

	// Widths of the beat fields.
	localparam int unsigned VALUE_W = 32;
	localparam int unsigned PRIO_W  = 8;
	localparam int unsigned OCC_W   = 5;
	localparam int unsigned STAT_W  = 2;

	// One stored queue entry.
	typedef struct packed {
		logic [PRIO_W-1:0]  prio;
		logic [VALUE_W-1:0] value;
	} entry_t;

	// Result status codes.
	typedef enum logic [STAT_W-1:0] {
		ST_DONE  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// Input beat kinds.
	typedef enum logic {
		MODE_INSERT = 1'b0,
		MODE_REMOVE = 1'b1
	} mode_t;

endpackage

`default_nettype wire

// ----- rtl/priority_queue_sorted_insert.sv -----
// ----------------------------------------------------------------------------
// priority_queue_sorted_insert: bounded priority queue kept in service order.
// Inserts are placed behind every entry of lower or equal priority number;
// removes take the head entry.
// ----------------------------------------------------------------------------
// Usage:
// The slave channel takes one beat per request: tuser is the kind (insert or
// remove), tdata carries the value and the priority of an insert. Every beat
// gives exactly one result beat on the master channel: the removed value, a
// status (done, remove on empty, insert dropped because full) and the number
// of entries held afterwards.
// Entries live in a circular single-port memory of CAPACITY words with a head
// pointer. A remove reads the head slot, then advances the pointer; drops and
// empty removes go straight to the result step. An insert walks back from the
// tail with one read and one compare-and-move for each entry, then writes the
// new entry. It moves 0 to CAPACITY-1 entries and stops behind an entry of
// lower or equal number or once every held entry has moved; an insert into
// an empty queue writes at once. s_tready is high only while no request is in
// work and rises with m_tvalid, so a new beat is not taken before the result
// of the last one appears. A finished result is held in the output register
// until taken; while the receiver stalls, the next request waits in its last
// step. Reset empties the queue at once; the memory needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module priority_queue_sorted_insert
	import pqsi_pkg::*;
#(
	parameter int unsigned CAPACITY = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Request channel.
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,   // [31:0] value, [39:32] priority_req
	input  wire logic        s_tuser,   // [0] mode
	// Result channel.
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata,   // [31:0] removed_value, [36:32] occupancy, zeros
	output logic [1:0]       m_tuser    // [1:0] status
);

	localparam int unsigned PTR_W = $clog2(CAPACITY);
	localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_CMP,
		S_PLACE,
		S_POP,
		S_FIN
	} state_t;

	state_t                state_q;
	entry_t                item_q;
	logic [PTR_W-1:0]      idx_q;
	logic [PTR_W-1:0]      head_q;
	logic [CNT_W-1:0]      count_q;
	logic [VALUE_W-1:0]    res_value_q;
	status_t               res_status_q;
	logic                  out_valid_q;
	logic [VALUE_W-1:0]    out_value_q;
	status_t               out_status_q;
	logic [OCC_W-1:0]      out_occ_q;

	entry_t                mem_q [CAPACITY];
	entry_t                rdata_q;
	logic                  rd_en;
	logic [PTR_W-1:0]      rd_addr;
	logic                  wr_en;
	logic [PTR_W-1:0]      wr_addr;
	entry_t                wr_data;

	logic                  in_beat;
	logic                  out_free;
	logic                  is_full;
	logic                  shift_move;

	// Logical position in the queue to physical memory slot.
	function automatic logic [PTR_W-1:0] phys(input logic [PTR_W-1:0] head,
		input logic [PTR_W-1:0] off);
		logic [PTR_W:0] sum;
		sum = {1'b0, head} + {1'b0, off};
		if (sum >= (PTR_W+1)'(CAPACITY)) begin
			sum = sum - (PTR_W+1)'(CAPACITY);
		end
		return sum[PTR_W-1:0];
	endfunction

	// Handshake and compare decode.
	assign s_tready   = (state_q == S_IDLE);
	assign in_beat    = s_tvalid && s_tready;
	assign out_free   = !out_valid_q || m_tready;
	assign is_full    = (count_q == CNT_W'(CAPACITY));
	assign shift_move = (rdata_q.prio > item_q.prio);

	// Memory port control: read the head on a remove, the entry in front of
	// the hole while walking an insert; write moves and the new entry.
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = head_q;
		wr_en   = 1'b0;
		wr_addr = phys(head_q, idx_q);
		wr_data = item_q;
		if (state_q == S_IDLE) begin
			rd_en = in_beat && (s_tuser == MODE_REMOVE);
		end else if (state_q == S_READ) begin
			rd_en   = 1'b1;
			rd_addr = phys(head_q, idx_q - PTR_W'(1));
		end else if (state_q == S_CMP) begin
			wr_en   = shift_move;
			wr_data = rdata_q;
		end else if (state_q == S_PLACE) begin
			wr_en = 1'b1;
		end
	end

	// Entry memory with registered read data.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q <= mem_q[rd_addr];
		end
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Sequencer, queue pointers and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			item_q       <= '0;
			idx_q        <= '0;
			head_q       <= '0;
			count_q      <= '0;
			res_value_q  <= '0;
			res_status_q <= ST_DONE;
			out_valid_q  <= 1'b0;
			out_value_q  <= '0;
			out_status_q <= ST_DONE;
			out_occ_q    <= '0;
		end else begin
			// The result register loads when a request finishes and clears once taken.
			if (state_q == S_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_beat) begin
						item_q      <= '{prio: s_tdata[39:32], value: s_tdata[31:0]};
						res_value_q <= '0;
						idx_q       <= count_q[PTR_W-1:0];
						if (s_tuser == MODE_REMOVE) begin
							if (count_q == '0) begin
								res_status_q <= ST_EMPTY;
								state_q      <= S_FIN;
							end else begin
								res_status_q <= ST_DONE;
								state_q      <= S_POP;
							end
						end else if (is_full) begin
							res_status_q <= ST_FULL;
							state_q      <= S_FIN;
						end else if (count_q == '0) begin
							res_status_q <= ST_DONE;
							state_q      <= S_PLACE;
						end else begin
							res_status_q <= ST_DONE;
							state_q      <= S_READ;
						end
					end
				end
				S_READ: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					// A larger priority number moves back one slot.
					if (shift_move) begin
						idx_q   <= idx_q - PTR_W'(1);
						state_q <= (idx_q == PTR_W'(1)) ? S_PLACE : S_READ;
					end else begin
						state_q <= S_PLACE;
					end
				end
				S_PLACE: begin
					count_q <= count_q + CNT_W'(1);
					state_q <= S_FIN;
				end
				S_POP: begin
					res_value_q <= rdata_q.value;
					head_q      <= (head_q == PTR_W'(CAPACITY - 1)) ? '0 :
						head_q + PTR_W'(1);
					count_q     <= count_q - CNT_W'(1);
					state_q     <= S_FIN;
				end
				S_FIN: begin
					if (out_free) begin
						out_value_q  <= res_value_q;
						out_status_q <= res_status_q;
						out_occ_q    <= OCC_W'(count_q);
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Result beat.
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, out_occ_q, out_value_q};
	assign m_tuser  = out_status_q;

	// Checks on the sequencer.
	`ASSERT_ALWAYS(a_count_bound, count_q <= CNT_W'(CAPACITY), "count above capacity")
	`ASSERT_NEXT(a_walk_count, state_q == S_READ || state_q == S_CMP,
		$stable(count_q) && $stable(head_q), "queue size changed during walk")
	`ASSERT_NEXT(a_move_step, state_q == S_CMP && shift_move,
		idx_q == $past(idx_q) - PTR_W'(1), "walk index did not step back")
	`ASSERT_NEXT(a_full_drop, in_beat && s_tuser == MODE_INSERT && is_full,
		state_q == S_FIN && res_status_q == ST_FULL && $stable(count_q),
		"insert into full queue not dropped")

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the sorted priority queue.
// A table of directed beats, then long random runs of inserts and removes,
// drive the request channel. A predictor with its own copy of the queue
// computes the expected beats; typed directed rows carry their own. Every
// beat taken from the result channel is compared field by field with them.
// ----------------------------------------------------------------------------

module testbench
	import pqsi_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CAPACITY      = 16;
	localparam int          RANDOM_ITEMS  = 1800;
	localparam int          CALM_ITEMS    = 200;
	localparam int          SETTLE_CYCLES = 2 * CAPACITY + 8;
	localparam int          STALL_LIMIT   = 1000;
	localparam int          SHOWN_ERRORS  = 10;

	// One result beat as the queue reports it.
	typedef struct packed {
		logic [VALUE_W-1:0] removed_value;
		status_t            status;
		logic [OCC_W-1:0]   occupancy;
	} result_t;

	// One row of the directed table. Rows marked typed carry their own result.
	typedef struct {
		mode_t             mode;
		logic [VALUE_W-1:0] value;
		logic [PRIO_W-1:0]  prio;
		bit                typed;
		result_t           want;
	} stim_row_t;

	localparam result_t COMPUTED = '0;

	logic               clk;
	logic               arst_n   = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [39:0]        s_tdata  = '0;   // [31:0] value, [39:32] priority_req
	logic               s_tuser  = 1'b0; // [0] mode
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [39:0]        m_tdata;         // [31:0] removed_value, [36:32] occupancy
	logic [1:0]         m_tuser;         // [1:0] status

	// Predictor state: the entries in service order and their number.
	logic [VALUE_W-1:0] held_value [CAPACITY];
	logic [PRIO_W-1:0]  held_prio  [CAPACITY];
	int unsigned        held_count = 0;

	result_t            pending_results [$];
	int                 failures    = 0;
	int                 idle_cycles = 0;
	bit                 quiet       = 1'b0;

	// Edge cases first: empty remove, extreme values and priorities, ties,
	// a long walk from the tail, and an insert into a full queue.
	stim_row_t directed_rows [25] = '{
		'{MODE_REMOVE, 32'h0000_0000, 8'd0,   1'b1, '{32'h0, ST_EMPTY, 5'd0}},
		'{MODE_INSERT, 32'h7FFF_FFFF, 8'd255, 1'b1, '{32'h0, ST_DONE, 5'd1}},
		'{MODE_INSERT, 32'h8000_0000, 8'd0,   1'b1, '{32'h0, ST_DONE, 5'd2}},
		'{MODE_INSERT, 32'h0000_0000, 8'd255, 1'b1, '{32'h0, ST_DONE, 5'd3}},
		'{MODE_INSERT, 32'hFFFF_FFFF, 8'd128, 1'b0, COMPUTED},
		'{MODE_INSERT, 32'hAAAA_AAAA, 8'd128, 1'b0, COMPUTED},
		'{MODE_INSERT, 32'h5555_5555, 8'd0,   1'b0, COMPUTED},
		'{MODE_REMOVE, 32'hFFFF_FFFF, 8'd255, 1'b0, COMPUTED},
		'{MODE_REMOVE, 32'h0000_0000, 8'd0,   1'b0, COMPUTED},
		'{MODE_INSERT, 32'h1234_5678, 8'd1,   1'b0, COMPUTED},
		'{MODE_INSERT, 32'h0000_0001, 8'd254, 1'b0, COMPUTED},
		'{MODE_INSERT, 32'h0000_0002, 8'd200, 1'b0, COMPUTED},
		'{MODE_INSERT, 32'h0000_0003, 8'd150, 1'b0, COMPUTED},
		'{MODE_INSERT, 32'h0000_0004, 8'd100, 1'b0, COMPUTED},
		'{MODE_INSERT, 32'hFFFF_FFFB, 8'd64,  1'b0, COMPUTED},
		'{MODE_INSERT, 32'hFFFF_FFFA, 8'd32,  1'b0, COMPUTED},
		'{MODE_INSERT, 32'h0F0F_F0F0, 8'd16,  1'b0, COMPUTED},
		'{MODE_INSERT, 32'hF0F0_0F0F, 8'd8,   1'b0, COMPUTED},
		'{MODE_INSERT, 32'h3C3C_C3C3, 8'd4,   1'b0, COMPUTED},
		'{MODE_INSERT, 32'hC3C3_3C3C, 8'd2,   1'b0, COMPUTED},
		'{MODE_INSERT, 32'h6996_9669, 8'd1,   1'b0, COMPUTED},
		'{MODE_INSERT, 32'h0F0F_0F0F, 8'd0,   1'b1, '{32'h0, ST_FULL, 5'd16}},
		'{MODE_REMOVE, 32'h0000_0000, 8'd0,   1'b0, COMPUTED},
		'{MODE_INSERT, 32'hDEAD_BEEF, 8'd255, 1'b0, COMPUTED},
		'{MODE_REMOVE, 32'h0000_0000, 8'd0,   1'b0, COMPUTED}
	};

	priority_queue_sorted_insert #(
		.CAPACITY(CAPACITY)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Apply one request to the predicted queue and return the result it gives.
	function automatic result_t apply_request(mode_t mode, logic [VALUE_W-1:0] value,
			logic [PRIO_W-1:0] prio);
		result_t     res;
		int unsigned slot;
		res = '{'0, ST_DONE, '0};
		if (mode == MODE_REMOVE) begin
			if (held_count == 0) begin
				res.status = ST_EMPTY;
			end else begin
				res.removed_value = held_value[0];
				for (int i = 1; i < held_count; i++) begin
					held_value[i-1] = held_value[i];
					held_prio[i-1]  = held_prio[i];
				end
				held_count--;
			end
		end else if (held_count >= CAPACITY) begin
			res.status = ST_FULL;
		end else begin
			// The new entry goes behind every entry of lower or equal number.
			slot = 0;
			while (slot < held_count && held_prio[slot] <= prio)
				slot++;
			for (int i = held_count; i > slot; i--) begin
				held_value[i] = held_value[i-1];
				held_prio[i]  = held_prio[i-1];
			end
			held_value[slot] = value;
			held_prio[slot]  = prio;
			held_count++;
		end
		res.occupancy = held_count[OCC_W-1:0];
		return res;
	endfunction

	// Offer one request beat, possibly after an idle burst, and record its result.
	task automatic send_request(mode_t mode, logic [VALUE_W-1:0] value,
			logic [PRIO_W-1:0] prio, bit typed, result_t want);
		result_t predicted;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {prio, value};
		s_tuser  <= mode;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predicted = apply_request(mode, value, prio);
		pending_results.push_back(typed ? want : predicted);
	endtask

	// Hold the sender back until every outstanding result has come out.
	task automatic wait_for_drain();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// Stimulus: directed table, then random runs with changing bias.
	initial begin
		int                 sent;
		int                 run_len;
		int                 insert_pct;
		int                 prio_kind;
		mode_t              mode;
		logic [PRIO_W-1:0]  prio;
		sent = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[r])
			send_request(directed_rows[r].mode, directed_rows[r].value,
				directed_rows[r].prio, directed_rows[r].typed, directed_rows[r].want);
		wait_for_drain();

		while (sent < RANDOM_ITEMS) begin
			run_len   = $urandom_range(20, 120);
			prio_kind = $urandom_range(0, 2);
			case ($urandom_range(0, 2))
				0: begin
					insert_pct = 85;
				end
				1: begin
					insert_pct = 15;
				end
				default: begin
					insert_pct = 50;
				end
			endcase
			for (int i = 0; i < run_len && sent < RANDOM_ITEMS; i++) begin
				quiet = (RANDOM_ITEMS - sent) <= CALM_ITEMS;
				mode  = ($urandom_range(0, 99) < insert_pct) ? MODE_INSERT : MODE_REMOVE;
				// Narrow ranges make ties common; the full range reaches every bit.
				case (prio_kind)
					0: begin
						prio = PRIO_W'($urandom_range(0, 3));
					end
					1: begin
						prio = $urandom_range(0, 1) ? 8'hFF : 8'h00;
					end
					default: begin
						prio = PRIO_W'($urandom);
					end
				endcase
				send_request(mode, $urandom, prio, 1'b0, COMPUTED);
				sent++;
				if (sent == RANDOM_ITEMS / 2)
					wait_for_drain();
			end
		end

		// Let the last results come out, then give the block time to go quiet.
		wait_for_drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

	// The receiver stalls in bursts, except in the calm tail of the run.
	initial begin
		forever begin
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 40)) @(posedge clk);
			if (!quiet && $urandom_range(0, 1) == 1) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end
		end
	end

	// Check every result beat against the oldest expected result.
	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = '{m_tdata[VALUE_W-1:0], status_t'(m_tuser), m_tdata[VALUE_W+OCC_W-1:VALUE_W]};
			if (pending_results.size() == 0) begin
				failures++;
				if (failures <= SHOWN_ERRORS)
					$display("%0t: result beat with none expected: value %h status %0d occ %0d",
						$realtime, got.removed_value, got.status, got.occupancy);
			end else begin
				want = pending_results.pop_front();
				if (got.removed_value !== want.removed_value || got.status !== want.status ||
						got.occupancy !== want.occupancy) begin
					failures++;
					if (failures <= SHOWN_ERRORS)
						$display("%0t: mismatch: value %h/%h status %0d/%0d occ %0d/%0d (exp/act)",
							$realtime, want.removed_value, got.removed_value, want.status,
							got.status, want.occupancy, got.occupancy);
				end
			end
		end
	end

	// Watchdog: too many cycles without any beat on either channel.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("testbench: FAIL");
				$finish;
			end
		end
	end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/pqsi_pkg.sv
rtl/priority_queue_sorted_insert.sv
sim/testbench.sv
